>>> sv/i2p_pkg.sv
// i2p_pkg: types, codes and helpers of the infix-to-postfix tokenizer
// no dependencies
`default_nettype none
package i2p_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       final_char;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [30:0] number_value;
		logic [3:0]  operator_code;
		logic        function_code;
		logic [2:0]  error_code;
		logic        run_end;
	} out_word_t;

	localparam logic [2:0] TK_NUM = 3'd0;
	localparam logic [2:0] TK_T   = 3'd1;
	localparam logic [2:0] TK_X   = 3'd2;
	localparam logic [2:0] TK_FN  = 3'd3;
	localparam logic [2:0] TK_OP  = 3'd4;
	localparam logic [2:0] TK_END = 3'd5;
	localparam logic [2:0] TK_ERR = 3'd6;

	localparam logic [3:0] E_ADD = 4'd0;
	localparam logic [3:0] E_SUB = 4'd1;
	localparam logic [3:0] E_MUL = 4'd2;
	localparam logic [3:0] E_DIV = 4'd3;
	localparam logic [3:0] E_MOD = 4'd4;
	localparam logic [3:0] E_AND = 4'd5;
	localparam logic [3:0] E_OR  = 4'd6;
	localparam logic [3:0] E_XOR = 4'd7;
	localparam logic [3:0] E_SHL = 4'd8;
	localparam logic [3:0] E_SHR = 4'd9;
	localparam logic [3:0] E_SIN = 4'd10;
	localparam logic [3:0] E_COS = 4'd11;
	localparam logic [3:0] E_OPEN = 4'd12;
	localparam logic [3:0] OP_FN = 4'd10;

	localparam logic [2:0] ER_NONE  = 3'd0;
	localparam logic [2:0] ER_BAD   = 3'd1;
	localparam logic [2:0] ER_CLOSE = 3'd2;
	localparam logic [2:0] ER_OPEN  = 3'd3;
	localparam logic [2:0] ER_OVF   = 3'd4;
	localparam logic [2:0] ER_FULL  = 3'd5;

	localparam logic [2:0] LA_IDLE = 3'd0;
	localparam logic [2:0] LA_S    = 3'd1;
	localparam logic [2:0] LA_SI   = 3'd2;
	localparam logic [2:0] LA_C    = 3'd3;
	localparam logic [2:0] LA_CO   = 3'd4;
	localparam logic [2:0] LA_LT   = 3'd5;
	localparam logic [2:0] LA_GT   = 3'd6;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_POP,
		ST_PUSH,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	// what the current character asks for
	typedef enum logic [2:0] {
		AC_NONE,
		AC_PUSH_POP,
		AC_PUSH,
		AC_CLOSE
	} act_t;

	typedef struct packed {
		logic       load;
		logic       pop;
		logic       push;
		logic       drop_top;
		logic       clear;
		logic       emit_number;
		logic       emit_pending;
	} cmd_t;

	typedef struct packed {
		logic       number_open;
		logic       dig;
		logic       empty;
		logic       full;
		logic [3:0] top;
		logic [3:0] entry;
		act_t       act;
		logic [2:0] err;
		logic       fin;
		logic       la_open;
		logic       has_tok;
	} sts_t;

	function automatic logic [2:0] prec_of(input logic [3:0] e);
		logic [2:0] p;
		case (e)
			E_ADD, E_SUB:        p = 3'd4;
			E_MUL, E_DIV, E_MOD: p = 3'd5;
			E_AND:               p = 3'd2;
			E_OR:                p = 3'd0;
			E_XOR:               p = 3'd1;
			E_SHL, E_SHR:        p = 3'd3;
			default:             p = 3'd6;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

>>> sv/i2p_ram.sv
// i2p_ram: generic RAM with one write port and one read port, with registered read
// no dependencies
`default_nettype none
module i2p_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/i2p_datapath.sv
// i2p_datapath: character decode, number accumulator, lookahead and operator stack
// depends on i2p_pkg, i2p_ram
`default_nettype none
module i2p_datapath #(
	parameter int DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire i2p_pkg::in_word_t in_word,
	input  wire i2p_pkg::cmd_t     cmd,
	output i2p_pkg::sts_t          sts,
	output i2p_pkg::out_word_t     tok
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [2:0]    la_q;
	logic [30:0]   acc_q;
	logic          nopen_q;
	logic [CW-1:0] cnt_q;
	logic          dig_q;
	logic          fin_q;
	logic [3:0]    entry_q;
	i2p_pkg::act_t act_q;
	logic [2:0]    err_q;
	logic          has_q;
	i2p_pkg::out_word_t pend_q;
	logic [3:0]    top;

	logic [3:0]    d_entry;
	i2p_pkg::act_t d_act;
	logic [2:0]    d_err, d_la;
	logic          d_has, d_dig;
	i2p_pkg::out_word_t d_tok;
	logic [34:0]   prod;
	logic [AW-1:0] raddr, waddr;

	assign prod = 35'(in_word.char_code[3:0]) + ({4'd0, acc_q} << 3)
		+ ({4'd0, acc_q} << 1);

	always_comb begin
		d_entry = i2p_pkg::E_ADD;
		d_act   = i2p_pkg::AC_NONE;
		d_err   = i2p_pkg::ER_NONE;
		d_la    = i2p_pkg::LA_IDLE;
		d_has   = 1'b0;
		d_dig   = 1'b0;
		d_tok   = '0;
		if (la_q != i2p_pkg::LA_IDLE) begin
			unique case (la_q)
				i2p_pkg::LA_S:  if (in_word.char_code == "i") d_la = i2p_pkg::LA_SI;
					else d_err = i2p_pkg::ER_BAD;
				i2p_pkg::LA_SI: if (in_word.char_code == "n") begin
					d_entry = i2p_pkg::E_SIN; d_act = i2p_pkg::AC_PUSH;
				end else d_err = i2p_pkg::ER_BAD;
				i2p_pkg::LA_C:  if (in_word.char_code == "o") d_la = i2p_pkg::LA_CO;
					else d_err = i2p_pkg::ER_BAD;
				i2p_pkg::LA_CO: if (in_word.char_code == "s") begin
					d_entry = i2p_pkg::E_COS; d_act = i2p_pkg::AC_PUSH;
				end else d_err = i2p_pkg::ER_BAD;
				i2p_pkg::LA_LT: if (in_word.char_code == "<") begin
					d_entry = i2p_pkg::E_SHL; d_act = i2p_pkg::AC_PUSH_POP;
				end else d_err = i2p_pkg::ER_BAD;
				i2p_pkg::LA_GT: if (in_word.char_code == ">") begin
					d_entry = i2p_pkg::E_SHR; d_act = i2p_pkg::AC_PUSH_POP;
				end else d_err = i2p_pkg::ER_BAD;
				default: d_err = i2p_pkg::ER_BAD;
			endcase
		end else if (in_word.char_code >= "0" && in_word.char_code <= "9") begin
			d_dig = 1'b1;
			if (prod > {4'd0, i2p_pkg::NUM_MAX}) d_err = i2p_pkg::ER_OVF;
		end else begin
			unique case (in_word.char_code)
				"s": d_la = i2p_pkg::LA_S;
				"c": d_la = i2p_pkg::LA_C;
				"<": d_la = i2p_pkg::LA_LT;
				">": d_la = i2p_pkg::LA_GT;
				"t": begin d_has = 1'b1; d_tok.token_kind = i2p_pkg::TK_T; end
				"x": begin d_has = 1'b1; d_tok.token_kind = i2p_pkg::TK_X; end
				"+": begin d_entry = i2p_pkg::E_ADD; d_act = i2p_pkg::AC_PUSH_POP; end
				"-": begin d_entry = i2p_pkg::E_SUB; d_act = i2p_pkg::AC_PUSH_POP; end
				"*": begin d_entry = i2p_pkg::E_MUL; d_act = i2p_pkg::AC_PUSH_POP; end
				"/": begin d_entry = i2p_pkg::E_DIV; d_act = i2p_pkg::AC_PUSH_POP; end
				"%": begin d_entry = i2p_pkg::E_MOD; d_act = i2p_pkg::AC_PUSH_POP; end
				"&": begin d_entry = i2p_pkg::E_AND; d_act = i2p_pkg::AC_PUSH_POP; end
				"|": begin d_entry = i2p_pkg::E_OR;  d_act = i2p_pkg::AC_PUSH_POP; end
				"^": begin d_entry = i2p_pkg::E_XOR; d_act = i2p_pkg::AC_PUSH_POP; end
				"(": begin d_entry = i2p_pkg::E_OPEN; d_act = i2p_pkg::AC_PUSH; end
				")": d_act = i2p_pkg::AC_CLOSE;
				" ": ;
				default: d_err = i2p_pkg::ER_BAD;
			endcase
		end
	end

	assign raddr = cmd.pop ? AW'(cnt_q - CW'(2)) : AW'(cnt_q - CW'(1));
	assign waddr = AW'(cnt_q);

	i2p_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_stack (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (waddr),
		.wdata (entry_q),
		.raddr (raddr),
		.rdata (top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q    <= i2p_pkg::LA_IDLE;
			acc_q   <= '0;
			nopen_q <= 1'b0;
			cnt_q   <= '0;
			act_q   <= i2p_pkg::AC_NONE;
			err_q   <= i2p_pkg::ER_NONE;
			has_q   <= 1'b0;
			fin_q   <= 1'b0;
			dig_q   <= 1'b0;
		end else if (cmd.clear) begin
			la_q    <= i2p_pkg::LA_IDLE;
			acc_q   <= '0;
			nopen_q <= 1'b0;
			cnt_q   <= '0;
			act_q   <= i2p_pkg::AC_NONE;
			err_q   <= i2p_pkg::ER_NONE;
			has_q   <= 1'b0;
		end else if (cmd.load) begin
			fin_q   <= in_word.final_char;
			dig_q   <= d_dig;
			entry_q <= d_entry;
			act_q   <= d_act;
			err_q   <= d_err;
			la_q    <= d_la;
			has_q   <= d_has;
			pend_q  <= d_tok;
			if (d_dig && d_err == i2p_pkg::ER_NONE) begin
				acc_q   <= prod[30:0];
				nopen_q <= 1'b1;
			end
		end else begin
			if (cmd.emit_number) begin
				nopen_q <= 1'b0;
				acc_q   <= '0;
			end
			if (cmd.emit_pending) has_q <= 1'b0;
			if (cmd.pop || cmd.drop_top) cnt_q <= cnt_q - CW'(1);
			if (cmd.push) begin
				cnt_q <= cnt_q + CW'(1);
				act_q <= i2p_pkg::AC_NONE;
			end
		end
	end

	always_comb begin
		tok = '0;
		if (cmd.emit_number) begin
			tok.token_kind   = i2p_pkg::TK_NUM;
			tok.number_value = acc_q;
		end else if (cmd.emit_pending) begin
			tok = pend_q;
		end else if (top == i2p_pkg::E_SIN || top == i2p_pkg::E_COS) begin
			tok.token_kind    = i2p_pkg::TK_FN;
			tok.operator_code = i2p_pkg::OP_FN;
			tok.function_code = top[0];
		end else begin
			tok.token_kind    = i2p_pkg::TK_OP;
			tok.operator_code = top;
		end
	end

	assign sts.number_open = nopen_q;
	assign sts.dig     = dig_q;
	assign sts.empty   = (cnt_q == '0);
	assign sts.full    = (cnt_q >= CW'(DEPTH));
	assign sts.top     = top;
	assign sts.entry   = entry_q;
	assign sts.act     = act_q;
	assign sts.err     = err_q;
	assign sts.fin     = fin_q;
	assign sts.la_open = (la_q != i2p_pkg::LA_IDLE);
	assign sts.has_tok = has_q;
endmodule
`default_nettype wire

>>> sv/i2p_ctrl.sv
// i2p_ctrl: sequencer for one character, stack pops, pushes and final flush
// depends on i2p_pkg
`default_nettype none
module i2p_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           in_final,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire i2p_pkg::sts_t  sts,
	input  wire i2p_pkg::out_word_t tok,
	output i2p_pkg::cmd_t       cmd,
	output i2p_pkg::out_word_t  out_word
);
	i2p_pkg::state_t st_q, st_d;
	logic ovalid_q, skip_q, skip_d, fl_q, fl_d;
	i2p_pkg::out_word_t oword_q;
	logic emit;
	i2p_pkg::out_word_t etok;
	logic free;

	assign free      = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign out_word  = oword_q;

	// the stack top is a registered RAM read that follows the count; ST_READ waits for it
	always_comb begin
		st_d   = st_q;
		skip_d = skip_q;
		fl_d   = fl_q;
		cmd    = '0;
		emit   = 1'b0;
		etok   = tok;
		in_ready = 1'b0;
		unique case (st_q)
			i2p_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (skip_q) begin
						if (in_final) skip_d = 1'b0;
					end else begin
						cmd.load = 1'b1;
						fl_d     = 1'b0;
						st_d     = i2p_pkg::ST_READ;
					end
				end
			end
			i2p_pkg::ST_READ: st_d = i2p_pkg::ST_EMIT;
			i2p_pkg::ST_EMIT: begin
				if (fl_q) begin
					st_d = i2p_pkg::ST_FLUSH;
				end else if (sts.number_open && !sts.dig) begin
					if (free) begin
						cmd.emit_number = 1'b1;
						emit = 1'b1;
					end
				end else if (sts.err != i2p_pkg::ER_NONE) begin
					st_d = i2p_pkg::ST_FLUSH;
				end else if (sts.has_tok) begin
					if (free) begin
						cmd.emit_pending = 1'b1;
						emit = 1'b1;
					end
				end else begin
					st_d = i2p_pkg::ST_POP;
				end
			end
			i2p_pkg::ST_POP: begin
				unique case (sts.act)
					i2p_pkg::AC_PUSH_POP: begin
						if (!sts.empty && sts.top != i2p_pkg::E_OPEN
								&& i2p_pkg::prec_of(sts.top) >= i2p_pkg::prec_of(sts.entry)) begin
							if (free) begin
								emit = 1'b1; cmd.pop = 1'b1; st_d = i2p_pkg::ST_READ;
							end
						end else st_d = i2p_pkg::ST_PUSH;
					end
					i2p_pkg::AC_PUSH: st_d = i2p_pkg::ST_PUSH;
					i2p_pkg::AC_CLOSE: begin
						if (sts.empty) begin
							if (free) begin
								emit = 1'b1;
								etok = '0;
								etok.token_kind = i2p_pkg::TK_ERR;
								etok.error_code = i2p_pkg::ER_CLOSE;
								etok.run_end = 1'b1;
								cmd.clear = 1'b1;
								skip_d = !sts.fin;
								st_d = i2p_pkg::ST_IDLE;
							end
						end else if (sts.top != i2p_pkg::E_OPEN) begin
							if (free) begin
								emit = 1'b1; cmd.pop = 1'b1; st_d = i2p_pkg::ST_READ;
							end
						end else begin
							cmd.drop_top = 1'b1;
							st_d = i2p_pkg::ST_PUSH;
						end
					end
					default: st_d = i2p_pkg::ST_PUSH;
				endcase
			end
			i2p_pkg::ST_PUSH: begin
				if (sts.act == i2p_pkg::AC_PUSH || sts.act == i2p_pkg::AC_PUSH_POP) begin
					if (sts.full) begin
						if (free) begin
							emit = 1'b1;
							etok = '0;
							etok.token_kind = i2p_pkg::TK_ERR;
							etok.error_code = i2p_pkg::ER_FULL;
							etok.run_end = 1'b1;
							cmd.clear = 1'b1;
							skip_d = !sts.fin;
							st_d = i2p_pkg::ST_IDLE;
						end
					end else begin
						cmd.push = 1'b1;
						st_d = sts.fin ? i2p_pkg::ST_READ : i2p_pkg::ST_IDLE;
						fl_d = sts.fin;
					end
				end else if (sts.fin) begin
					fl_d = 1'b1;
					st_d = i2p_pkg::ST_READ;
				end else st_d = i2p_pkg::ST_IDLE;
			end
			i2p_pkg::ST_FLUSH: begin
				if (free) begin
					if (sts.err != i2p_pkg::ER_NONE || sts.la_open) begin
						emit = 1'b1;
						etok = '0;
						etok.token_kind = i2p_pkg::TK_ERR;
						etok.error_code = (sts.err != i2p_pkg::ER_NONE) ? sts.err
							: i2p_pkg::ER_BAD;
						etok.run_end = 1'b1;
						cmd.clear = 1'b1;
						skip_d = !sts.fin;
						st_d = i2p_pkg::ST_IDLE;
					end else if (sts.number_open) begin
						emit = 1'b1; cmd.emit_number = 1'b1;
					end else if (sts.empty) begin
						emit = 1'b1;
						etok = '0;
						etok.token_kind = i2p_pkg::TK_END;
						etok.run_end = 1'b1;
						cmd.clear = 1'b1;
						st_d = i2p_pkg::ST_IDLE;
					end else if (sts.top == i2p_pkg::E_OPEN) begin
						emit = 1'b1;
						etok = '0;
						etok.token_kind = i2p_pkg::TK_ERR;
						etok.error_code = i2p_pkg::ER_OPEN;
						etok.run_end = 1'b1;
						cmd.clear = 1'b1;
						st_d = i2p_pkg::ST_IDLE;
					end else begin
						emit = 1'b1; cmd.pop = 1'b1; st_d = i2p_pkg::ST_READ;
					end
				end
			end
			default: st_d = i2p_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= i2p_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
			skip_q   <= 1'b0;
			fl_q     <= 1'b0;
		end else begin
			st_q   <= st_d;
			skip_q <= skip_d;
			fl_q   <= fl_d;
			if (emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) oword_q <= etok;
	end
endmodule
`default_nettype wire

>>> sv/infix_to_postfix_tokenizer_core.sv
// infix_to_postfix_tokenizer_core: top level of the shunting-yard tokenizer
// depends on i2p_pkg, i2p_ctrl, i2p_datapath
`default_nettype none
// Takes one expression character per input word and sends postfix tokens, one per
// output word. A character runs through these steps before the next is accepted:
// load, a wait for the registered read of the operator stack RAM, a token check,
// a pop decision and a push or pass. A closed number or a t or x token adds an emit
// step; each popped operator or function repeats the read wait, token check and pop
// decision. The last character of an expression also runs the flush, which sends any
// open number, each popped entry and the end token. An error is sent from the flush,
// pop or push state after the token check of its character; the characters that
// follow it up to the final one are dropped on acceptance. A stalled output holds the
// sequencer until the output register frees. The stack RAM is not cleared after reset.
module infix_to_postfix_tokenizer_core #(
	parameter int OP_STACK_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire i2p_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output i2p_pkg::out_word_t      out_data
);
	i2p_pkg::cmd_t      cmd;
	i2p_pkg::sts_t      sts;
	i2p_pkg::out_word_t tok;

	i2p_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_final  (in_data.final_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.tok       (tok),
		.cmd       (cmd),
		.out_word  (out_data)
	);

	i2p_datapath #(.DEPTH(OP_STACK_DEPTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.tok     (tok)
	);
endmodule
`default_nettype wire

>>> verif/infix_to_postfix_tokenizer_core_test.sv
// testbench of the infix-to-postfix tokenizer: character words in, postfix token words out
// predicts every token with its own shunting-yard model and checks each one in order
// depends on i2p_pkg and infix_to_postfix_tokenizer_core
`default_nettype none
module infix_to_postfix_tokenizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	i2p_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	i2p_pkg::out_word_t out_data;

	infix_to_postfix_tokenizer_core #(.OP_STACK_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	i2p_pkg::in_word_t char_queue[$];
	i2p_pkg::out_word_t token_queue[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 0;
	bit stim_done = 0;

	// parser state of the model
	logic [2:0] la_phase;
	logic [30:0] digit_acc;
	bit num_open;
	logic [3:0] op_stack[DEPTH];
	int op_depth;
	bit skip_rest;

	function automatic logic [2:0] op_prec(input logic [3:0] e);
		case (e)
			i2p_pkg::E_ADD, i2p_pkg::E_SUB: return 3'd4;
			i2p_pkg::E_MUL, i2p_pkg::E_DIV, i2p_pkg::E_MOD: return 3'd5;
			i2p_pkg::E_AND: return 3'd2;
			i2p_pkg::E_OR: return 3'd0;
			i2p_pkg::E_XOR: return 3'd1;
			i2p_pkg::E_SHL, i2p_pkg::E_SHR: return 3'd3;
			default: return 3'd6;
		endcase
	endfunction

	task automatic add_token(input logic [2:0] kind, input logic [30:0] num,
			input logic [3:0] op, input logic fn, input logic [2:0] err, input logic fin);
		i2p_pkg::out_word_t w;
		w.token_kind = kind;
		w.number_value = num;
		w.operator_code = op;
		w.function_code = fn;
		w.error_code = err;
		w.run_end = fin;
		token_queue.insert(token_queue.size(), w);
	endtask

	task automatic add_entry(input logic [3:0] e);
		if (e == i2p_pkg::E_SIN || e == i2p_pkg::E_COS)
			add_token(i2p_pkg::TK_FN, '0, i2p_pkg::OP_FN, e == i2p_pkg::E_COS,
				i2p_pkg::ER_NONE, 1'b0);
		else
			add_token(i2p_pkg::TK_OP, '0, e, 1'b0, i2p_pkg::ER_NONE, 1'b0);
	endtask

	task automatic push_op(input logic [3:0] e, input bit pop_first, output logic [2:0] err);
		err = i2p_pkg::ER_NONE;
		if (pop_first)
			while (op_depth > 0 && op_stack[op_depth-1] != i2p_pkg::E_OPEN
					&& op_prec(op_stack[op_depth-1]) >= op_prec(e)) begin
				op_depth--;
				add_entry(op_stack[op_depth]);
			end
		if (op_depth >= DEPTH)
			err = i2p_pkg::ER_FULL;
		else begin
			op_stack[op_depth] = e;
			op_depth++;
		end
	endtask

	task automatic close_number();
		if (num_open) begin
			add_token(i2p_pkg::TK_NUM, digit_acc, '0, 1'b0, i2p_pkg::ER_NONE, 1'b0);
			num_open = 0;
			digit_acc = '0;
		end
	endtask

	task automatic clear_parse();
		la_phase = i2p_pkg::LA_IDLE;
		digit_acc = '0;
		num_open = 0;
		op_depth = 0;
	endtask

	task automatic predict_tokens(input i2p_pkg::in_word_t w);
		logic [7:0] c;
		logic [2:0] err;
		logic [2:0] ph;
		logic [34:0] v;
		bit fin;
		c = w.char_code;
		fin = w.final_char;
		err = i2p_pkg::ER_NONE;
		if (skip_rest) begin
			if (fin)
				skip_rest = 0;
			return;
		end
		if (la_phase != i2p_pkg::LA_IDLE) begin
			ph = la_phase;
			la_phase = i2p_pkg::LA_IDLE;
			if (ph == i2p_pkg::LA_S && c == "i") la_phase = i2p_pkg::LA_SI;
			else if (ph == i2p_pkg::LA_SI && c == "n") push_op(i2p_pkg::E_SIN, 0, err);
			else if (ph == i2p_pkg::LA_C && c == "o") la_phase = i2p_pkg::LA_CO;
			else if (ph == i2p_pkg::LA_CO && c == "s") push_op(i2p_pkg::E_COS, 0, err);
			else if (ph == i2p_pkg::LA_LT && c == "<") push_op(i2p_pkg::E_SHL, 1, err);
			else if (ph == i2p_pkg::LA_GT && c == ">") push_op(i2p_pkg::E_SHR, 1, err);
			else err = i2p_pkg::ER_BAD;
		end else if (c >= "0" && c <= "9") begin
			v = digit_acc * 35'd10 + (c - "0");
			if (v > i2p_pkg::NUM_MAX)
				err = i2p_pkg::ER_OVF;
			else begin
				digit_acc = v[30:0];
				num_open = 1;
			end
		end else begin
			close_number();
			case (c)
				"s": la_phase = i2p_pkg::LA_S;
				"c": la_phase = i2p_pkg::LA_C;
				"<": la_phase = i2p_pkg::LA_LT;
				">": la_phase = i2p_pkg::LA_GT;
				"t": add_token(i2p_pkg::TK_T, '0, '0, 1'b0, i2p_pkg::ER_NONE, 1'b0);
				"x": add_token(i2p_pkg::TK_X, '0, '0, 1'b0, i2p_pkg::ER_NONE, 1'b0);
				"+": push_op(i2p_pkg::E_ADD, 1, err);
				"-": push_op(i2p_pkg::E_SUB, 1, err);
				"*": push_op(i2p_pkg::E_MUL, 1, err);
				"/": push_op(i2p_pkg::E_DIV, 1, err);
				"%": push_op(i2p_pkg::E_MOD, 1, err);
				"&": push_op(i2p_pkg::E_AND, 1, err);
				"|": push_op(i2p_pkg::E_OR, 1, err);
				"^": push_op(i2p_pkg::E_XOR, 1, err);
				"(": push_op(i2p_pkg::E_OPEN, 0, err);
				")": begin
					while (op_depth > 0 && op_stack[op_depth-1] != i2p_pkg::E_OPEN) begin
						op_depth--;
						add_entry(op_stack[op_depth]);
					end
					if (op_depth == 0)
						err = i2p_pkg::ER_CLOSE;
					else
						op_depth--;
				end
				" ": ;
				default: err = i2p_pkg::ER_BAD;
			endcase
		end
		if (err == i2p_pkg::ER_NONE && fin) begin
			if (la_phase != i2p_pkg::LA_IDLE)
				err = i2p_pkg::ER_BAD;
			else begin
				close_number();
				while (op_depth > 0) begin
					op_depth--;
					if (op_stack[op_depth] == i2p_pkg::E_OPEN) begin
						err = i2p_pkg::ER_OPEN;
						break;
					end
					add_entry(op_stack[op_depth]);
				end
				if (err == i2p_pkg::ER_NONE) begin
					add_token(i2p_pkg::TK_END, '0, '0, 1'b0, i2p_pkg::ER_NONE, 1'b1);
					clear_parse();
				end
			end
		end
		if (err != i2p_pkg::ER_NONE) begin
			add_token(i2p_pkg::TK_ERR, '0, '0, 1'b0, err, 1'b1);
			clear_parse();
			skip_rest = !fin;
		end
	endtask

	task automatic report_mismatch(input string what, input i2p_pkg::out_word_t got);
		$display("mismatch: %s, got kind %0d num %0d op %0d fn %0d err %0d end %0d",
			what, got.token_kind, got.number_value, got.operator_code,
			got.function_code, got.error_code, got.run_end);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_tokens(in_data);
			if (!in_valid || in_ready) begin
				if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= char_queue.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (token_queue.size() == 0)
					report_mismatch("token with none expected", out_data);
				else if (out_data !== token_queue[0]) begin
					report_mismatch("token fields differ", out_data);
					void'(token_queue.pop_front());
				end else
					void'(token_queue.pop_front());
			end
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_text(input string s);
		i2p_pkg::in_word_t w;
		for (int i = 0; i < s.len(); i++) begin
			w.char_code = s[i];
			w.final_char = (i == s.len() - 1);
			char_queue.insert(char_queue.size(), w);
		end
	endtask

	task automatic wait_drained();
		while (char_queue.size() > 0 || in_valid || token_queue.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic string random_expr();
		string s;
		string ops[12];
		int n;
		int open;
		ops = '{"+", "-", "*", "/", "%", "&", "|", "^", "<<", ">>", " + ", "*"};
		s = "";
		open = 0;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: s = {s, "t"};
				1: s = {s, "x"};
				2: s = {s, $sformatf("%0d", $urandom_range(99999))};
				3: s = {s, "sin(", $sformatf("%0d", $urandom_range(9)), ")"};
				4: s = {s, "cos x"};
				default: begin
					s = {s, "(x"};
					open++;
				end
			endcase
			if (open > 0 && $urandom_range(2) == 0) begin
				s = {s, ")"};
				open--;
			end
			if (i < n - 1)
				s = {s, ops[$urandom_range(11)]};
		end
		while (open > 0) begin
			s = {s, ")"};
			open--;
		end
		return s;
	endfunction

	task automatic queue_random(input int count);
		string s;
		i2p_pkg::in_word_t w;
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) < 7) begin
				s = random_expr();
				if ($urandom_range(9) == 0)
					s[$urandom_range(s.len() - 1)] = $urandom_range(255);
				queue_text(s);
				sent += s.len();
			end else begin
				w.char_code = $urandom_range(255);
				w.final_char = $urandom_range(3) == 0;
				char_queue.insert(char_queue.size(), w);
				sent++;
			end
		end
		w.char_code = " ";
		w.final_char = 1'b1;
		char_queue.insert(char_queue.size(), w);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		clear_parse();
		skip_rest = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_text("2147483647+t*x-(3/4%5)&1|2^3<<4>>5");
		queue_text("sin(t)+cos x");
		queue_text("2147483648 9");
		queue_text("1)");
		queue_text("((1");
		queue_text("sx");
		queue_text("F");
		queue_text("c");
		queue_text("<=");
		queue_text({"1", {17{"+("}}, "1"});
		wait_drained();

		queue_random(25);
		wait_drained();

		// receiver held off while the sender keeps offering characters
		fork
			begin
				recv_hold = 1;
				repeat (400) @(posedge clk);
				recv_hold = 0;
			end
		join_none
		queue_text("1+2*3-4/5%6&7|8^9<<1>>2+t*x-sin(1)+cos(2)");
		wait_drained();

		send_idle_pct = 80;
		queue_random(25);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 80;
		queue_random(25);
		wait_drained();
		send_idle_pct = 34;
		recv_stall_pct = 34;
		queue_random(25);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(20);
		wait_drained();

		if (mismatches == 0 && token_queue.size() == 0)
			$display("infix_to_postfix_tokenizer_core_test passed");
		else
			$display("infix_to_postfix_tokenizer_core_test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("infix_to_postfix_tokenizer_core_test failed");
		$finish;
	end

endmodule
`default_nettype wire
